// File: rtl/rm2eu_pkg.sv
// ============================================================================
// rm2eu_pkg: shared types and constants for the rotation-to-Euler unit
// Axis-order decode table, CORDIC arctangent table, register indexes and
// the control bundle that travels with each matrix through the pipeline.
// ============================================================================
package rm2eu_pkg;

    localparam int NUM_ORDERS = 12;
    localparam int NUM_TERMS  = 7;

    // Slots of the per-order term list.
    localparam int SLOT_MID = 0;
    localparam int SLOT_FY  = 1;
    localparam int SLOT_FX  = 2;
    localparam int SLOT_TY  = 3;
    localparam int SLOT_TX  = 4;
    localparam int SLOT_LY  = 5;
    localparam int SLOT_LX  = 6;

    // Axis orders: the last valid code and the first proper-Euler code.
    localparam logic [3:0] ORDER_LAST   = 4'd11;
    localparam logic [3:0] ORDER_PROPER = 4'd6;

    // Configuration register indexes.
    localparam logic [3:0] REG_ORDER = 4'd0;
    localparam logic [3:0] REG_CONV  = 4'd1;
    localparam logic [3:0] REG_KIND  = 4'd2;
    localparam logic [3:0] REG_THR   = 4'd3;

    localparam int         THR_W     = 15;
    localparam int         CFG_W     = 15;
    localparam logic [14:0] THR_RESET = 15'd1;

    // Angles on a 2^32 full turn.
    localparam logic [31:0] Z_QUARTER = 32'h4000_0000;
    localparam logic [31:0] Z_HALF    = 32'h8000_0000;
    localparam logic [31:0] Z_3QUART  = 32'hC000_0000;

    // A term: bit 4 marks a sign-inverted element, bits 3:0 give row*3+col.
    typedef logic [4:0] term_t;

    // Per order: middle, first (y,x), third (y,x), locked first (y,x).
    // Codes 17, 18, 19, 21, 22, 23 are the negated elements 1, 2, 3, 5, 6, 7.
    localparam term_t ORDER_TAB [NUM_ORDERS][NUM_TERMS] = '{
        '{5'd2,  5'd17, 5'd0,  5'd21, 5'd8,  5'd3,  5'd4},
        '{5'd21, 5'd3,  5'd4,  5'd2,  5'd8,  5'd17, 5'd0},
        '{5'd17, 5'd2,  5'd0,  5'd7,  5'd4,  5'd22, 5'd8},
        '{5'd7,  5'd22, 5'd8,  5'd17, 5'd4,  5'd2,  5'd0},
        '{5'd3,  5'd21, 5'd4,  5'd22, 5'd0,  5'd7,  5'd8},
        '{5'd22, 5'd7,  5'd8,  5'd3,  5'd0,  5'd21, 5'd4},
        '{5'd8,  5'd22, 5'd23, 5'd18, 5'd5,  5'd17, 5'd0},
        '{5'd8,  5'd23, 5'd6,  5'd21, 5'd18, 5'd17, 5'd0},
        '{5'd0,  5'd17, 5'd18, 5'd19, 5'd6,  5'd21, 5'd4},
        '{5'd0,  5'd18, 5'd1,  5'd22, 5'd19, 5'd21, 5'd4},
        '{5'd4,  5'd19, 5'd5,  5'd17, 5'd23, 5'd22, 5'd0},
        '{5'd4,  5'd21, 5'd19, 5'd23, 5'd1,  5'd22, 5'd0}
    };

    // atan(2^-i) on a 2^32 full turn.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Control bundle carried alongside each matrix.
    typedef struct packed {
        logic        proper;
        logic        reserved;
        logic        intrinsic;
        logic [14:0] thr;
    } ctl_t;

endpackage

// File: rtl/rm2eu_front.sv
// ============================================================================
// rm2eu_front: input stage
// Transposes the matrix as the convention asks, decodes the axis order and
// picks the seven terms, clamping the middle element to +-1.
// ============================================================================
module rm2eu_front #(
    parameter int EW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [EW-1:0] m [9],
    input  logic [3:0]           order,
    input  logic                 conv,
    input  logic                 kind,
    input  logic [14:0]          thr,
    output logic                 out_valid,
    output logic [7*EW-1:0]      out_terms,
    output rm2eu_pkg::ctl_t      out_ctl
);

    localparam logic signed [EW-1:0] ONE     = {2'b01, {(EW-2){1'b0}}};
    localparam logic signed [EW-1:0] NEG_ONE = {2'b11, {(EW-2){1'b0}}};

    logic                 valid_reg;
    logic [7*EW-1:0]      terms_reg;
    logic [7*EW-1:0]      terms_next;
    rm2eu_pkg::ctl_t      ctl_reg;
    rm2eu_pkg::ctl_t      ctl_next;
    logic signed [EW-1:0] r [9];
    logic signed [EW-1:0] pick [7];
    logic                 reserved;
    logic [3:0]           oi;

    // Orientation of the matrix.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r[i*3+j] = (conv ^ kind) ? m[j*3+i] : m[i*3+j];
            end
        end
    end

    // Order decode and term selection; negation wraps.
    always_comb
    begin
        rm2eu_pkg::term_t t;
        logic signed [EW-1:0] v;
        t        = '0;
        v        = '0;
        reserved = (order > rm2eu_pkg::ORDER_LAST);
        oi       = reserved ? 4'd0 : order;
        for (int k = 0; k < 7; k++)
        begin
            t       = rm2eu_pkg::ORDER_TAB[oi][k];
            v       = r[t[3:0]];
            pick[k] = t[4] ? (EW'(0) - v) : v;
        end
        terms_next = '0;
        for (int k = 1; k < 7; k++)
        begin
            terms_next[k*EW +: EW] = pick[k];
        end
        if (pick[rm2eu_pkg::SLOT_MID] > ONE)
        begin
            terms_next[EW-1:0] = ONE;
        end
        else if (pick[rm2eu_pkg::SLOT_MID] < NEG_ONE)
        begin
            terms_next[EW-1:0] = NEG_ONE;
        end
        else
        begin
            terms_next[EW-1:0] = pick[rm2eu_pkg::SLOT_MID];
        end
        ctl_next.proper    = (oi >= rm2eu_pkg::ORDER_PROPER);
        ctl_next.reserved  = reserved;
        ctl_next.intrinsic = conv;
        ctl_next.thr       = thr;
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        terms_reg <= terms_next;
        ctl_reg   <= ctl_next;
    end

    assign out_valid = valid_reg;
    assign out_terms = terms_reg;
    assign out_ctl   = ctl_reg;

endmodule

// File: rtl/rm2eu_queue.sv
// ============================================================================
// rm2eu_queue: two-entry queue between front and back
// Decouples the input stage from the arithmetic pipeline; the head entry is
// handed to the back end in every cycle in which the queue holds a beat.
// ============================================================================
module rm2eu_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         pop;

    assign pop        = (count_reg != 2'd0);
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign pop_valid = pop;
    assign pop_data  = mem[rd_ptr_reg];

endmodule

// File: rtl/rm2eu_sqrt.sv
// ============================================================================
// rm2eu_sqrt: pipelined root of one minus the middle element squared
// One multiplier stage forms 1 - mid^2, then one restoring digit stage per
// result bit produces the exact floor square root.
// ============================================================================
module rm2eu_sqrt #(
    parameter int EW = 16,
    parameter int SW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [EW-1:0] in_mid,
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic [EW-2:0]        out_root,
    output logic [SW-1:0]        out_side
);

    localparam int K = EW - 1;
    localparam logic signed [2*EW-1:0] ONE_SQ = (2*EW)'(1) << (2*EW-4);

    logic [K:0]           v_reg;
    logic [2*K-1:0]       n_reg    [K+1];
    logic [K:0]           rem_reg  [K+1];
    logic [K-1:0]         root_reg [K+1];
    logic [SW-1:0]        side_reg [K+1];
    logic signed [2*EW-1:0] prod;
    logic signed [2*EW-1:0] diff;

    assign prod = in_mid * in_mid;
    assign diff = ONE_SQ - prod;

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[K-1:0], in_valid};
        end
    end

    // Square stage.
    always_ff @(posedge clk)
    begin
        n_reg[0]    <= diff[2*K-1:0];
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
    end

    // One root bit per stage.
    for (genvar s = 0; s < K; s++)
    begin : g_digit
        logic [K+2:0] cur;
        logic [K+2:0] trial;
        logic [K+2:0] sub;
        logic         ge;

        assign cur   = {rem_reg[s], n_reg[s][2*K-1 -: 2]};
        assign trial = {1'b0, root_reg[s], 2'b01};
        assign ge    = (cur >= trial);
        assign sub   = cur - trial;

        always_ff @(posedge clk)
        begin
            n_reg[s+1]    <= {n_reg[s][2*K-3:0], 2'b00};
            rem_reg[s+1]  <= ge ? sub[K:0] : cur[K:0];
            root_reg[s+1] <= {root_reg[s][K-2:0], ge};
            side_reg[s+1] <= side_reg[s];
        end
    end

    assign out_valid = v_reg[K];
    assign out_root  = root_reg[K];
    assign out_side  = side_reg[K];

endmodule

// File: rtl/rm2eu_cordic.sv
// ============================================================================
// rm2eu_cordic: pipelined CORDIC vectoring, several lanes in lockstep
// Each lane returns atan2(y, x) on a 2^32 full turn, one rotation per stage,
// with half-plane pre-rotation and the axis cases settled up front.
// ============================================================================
module rm2eu_cordic #(
    parameter int EW    = 16,
    parameter int STEPS = 16,
    parameter int SW    = 8,
    parameter int LANES = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [EW-1:0] in_y [LANES],
    input  logic signed [EW-1:0] in_x [LANES],
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic [31:0]          out_z [LANES],
    output logic [SW-1:0]        out_side
);

    localparam int W = EW + 31;

    logic [STEPS:0]  v_reg;
    logic [SW-1:0]   side_reg [STEPS+1];

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STEPS-1:0], in_valid};
        end
    end

    // Side data follows the lanes.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
    end
    for (genvar i = 0; i < STEPS; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[i+1] <= side_reg[i];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [W-1:0] xs [STEPS+1];
        logic signed [W-1:0] ys [STEPS+1];
        logic [31:0]         zs [STEPS+1];
        logic signed [EW:0]  xe;
        logic signed [EW:0]  ye;
        logic [31:0]         z0;

        // Axis cases and left half-plane pre-rotation. On the y axis both
        // operands go to zero so the stages leave the preset angle alone.
        always_comb
        begin
            xe = {in_x[l][EW-1], in_x[l]};
            ye = {in_y[l][EW-1], in_y[l]};
            z0 = '0;
            if (in_x[l] == '0)
            begin
                if (in_y[l] > 0)
                begin
                    z0 = rm2eu_pkg::Z_QUARTER;
                end
                else if (in_y[l] < 0)
                begin
                    z0 = rm2eu_pkg::Z_3QUART;
                end
                xe = '0;
                ye = '0;
            end
            else if (in_x[l] < 0)
            begin
                xe = -xe;
                ye = -ye;
                z0 = rm2eu_pkg::Z_HALF;
            end
        end

        always_ff @(posedge clk)
        begin
            xs[0] <= {{2{xe[EW]}}, xe, 28'd0};
            ys[0] <= {{2{ye[EW]}}, ye, 28'd0};
            zs[0] <= z0;
        end

        // Rotation stages.
        for (genvar i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [W-1:0] dx;
            logic signed [W-1:0] dy;
            logic signed [W-1:0] xn;
            logic signed [W-1:0] yn;
            logic [31:0]         zn;

            always_comb
            begin
                dx = xs[i] >>> i;
                dy = ys[i] >>> i;
                xn = xs[i];
                yn = ys[i];
                zn = zs[i];
                if (ys[i] > 0)
                begin
                    xn = xs[i] + dy;
                    yn = ys[i] - dx;
                    zn = zs[i] + rm2eu_pkg::ATAN_TAB[i];
                end
                else if (ys[i] < 0)
                begin
                    xn = xs[i] - dy;
                    yn = ys[i] + dx;
                    zn = zs[i] - rm2eu_pkg::ATAN_TAB[i];
                end
            end

            always_ff @(posedge clk)
            begin
                xs[i+1] <= xn;
                ys[i+1] <= yn;
                zs[i+1] <= zn;
            end
        end

        assign out_z[l] = zs[STEPS];
    end

    assign out_valid = v_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

// File: rtl/rotation_matrix_to_euler_angles_unit.sv
// ============================================================================
// rotation_matrix_to_euler_angles_unit: rotation matrix to Euler angles
// Converts a Q1.14 rotation matrix into three binary-angle Euler angles for
// any of the twelve axis orders, with gimbal-lock detection.
// ============================================================================
// The unit takes one matrix in every clock cycle and never stalls its
// caller: busy stays low in normal operation. Each matrix produces exactly
// one result beat, marked by done for one cycle, after passing the front,
// queue, square-root (one digit stage per root bit), select, CORDIC
// rotation and output registers. The receiver must take every result beat
// when it appears. Configuration is written through the cfg port while no
// matrix is in flight; the unit itself does not enforce this.
module rotation_matrix_to_euler_angles_unit #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ELEMENT_WIDTH-1:0] m00,
    input  logic signed [ELEMENT_WIDTH-1:0] m01,
    input  logic signed [ELEMENT_WIDTH-1:0] m02,
    input  logic signed [ELEMENT_WIDTH-1:0] m10,
    input  logic signed [ELEMENT_WIDTH-1:0] m11,
    input  logic signed [ELEMENT_WIDTH-1:0] m12,
    input  logic signed [ELEMENT_WIDTH-1:0] m20,
    input  logic signed [ELEMENT_WIDTH-1:0] m21,
    input  logic signed [ELEMENT_WIDTH-1:0] m22,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [3:0]                      cfg_index,
    input  logic [14:0]                     cfg_data,
    output logic                            done,
    output logic signed [ANGLE_WIDTH-1:0]   first_angle,
    output logic signed [ANGLE_WIDTH-1:0]   middle_angle,
    output logic signed [ANGLE_WIDTH-1:0]   third_angle,
    output logic                            degenerate
);

    localparam int EW    = ELEMENT_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam int K     = EW - 1;
    localparam int CTL_W = $bits(rm2eu_pkg::ctl_t);
    localparam int QW    = 7*EW + CTL_W;
    localparam int CW    = (K > 15) ? K : 15;
    localparam int SH    = 32 - AW;
    localparam logic [32:0] RND = (33'd1 << SH) >> 1;

    // Rounds a full-turn angle to the output width.
    function automatic logic [AW-1:0] to_angle(input logic [31:0] z);
        logic [32:0] sum;
        sum = {1'b0, z} + RND;
        return sum[SH +: AW];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [3:0]  order_reg;
    logic        conv_reg;
    logic        kind_reg;
    logic [14:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 4'd0;
            conv_reg  <= 1'b0;
            kind_reg  <= 1'b0;
            thr_reg   <= rm2eu_pkg::THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rm2eu_pkg::REG_ORDER: order_reg <= cfg_data[3:0];
                rm2eu_pkg::REG_CONV:  conv_reg  <= cfg_data[0];
                rm2eu_pkg::REG_KIND:  kind_reg  <= cfg_data[0];
                rm2eu_pkg::REG_THR:   thr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front: accept and classify.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] mat [9];
    logic                 f_valid;
    logic [7*EW-1:0]      f_terms;
    rm2eu_pkg::ctl_t      f_ctl;
    logic                 q_full;
    logic                 q_valid;
    logic [QW-1:0]        q_data;

    assign mat[0] = m00;
    assign mat[1] = m01;
    assign mat[2] = m02;
    assign mat[3] = m10;
    assign mat[4] = m11;
    assign mat[5] = m12;
    assign mat[6] = m20;
    assign mat[7] = m21;
    assign mat[8] = m22;

    assign busy = q_full;

    rm2eu_front #(.EW(EW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .m         (mat),
        .order     (order_reg),
        .conv      (conv_reg),
        .kind      (kind_reg),
        .thr       (thr_reg),
        .out_valid (f_valid),
        .out_terms (f_terms),
        .out_ctl   (f_ctl)
    );

    rm2eu_queue #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_data ({f_ctl, f_terms}),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    // ------------------------------------------------------------------
    // Back: square root of one minus the middle element squared.
    // ------------------------------------------------------------------
    logic            s_valid;
    logic [K-1:0]    s_root;
    logic [QW-1:0]   s_side;
    logic [7*EW-1:0] s_terms;
    rm2eu_pkg::ctl_t s_ctl;

    rm2eu_sqrt #(.EW(EW), .SW(QW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_mid    (q_data[EW-1:0]),
        .in_side   (q_data),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    assign s_terms = s_side[7*EW-1:0];
    assign s_ctl   = s_side[7*EW +: CTL_W];

    // Gimbal-lock test and CORDIC operand selection.
    logic                 sel_valid_reg;
    logic                 sel_degen_reg;
    rm2eu_pkg::ctl_t      sel_ctl_reg;
    logic signed [EW-1:0] sel_y_reg [3];
    logic signed [EW-1:0] sel_x_reg [3];
    logic                 degen_next;
    logic signed [EW-1:0] root_s;
    logic signed [EW-1:0] mid_s;

    assign degen_next = (CW'(s_root) <= CW'(s_ctl.thr));
    assign root_s     = {1'b0, s_root};
    assign mid_s      = s_terms[EW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            sel_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_degen_reg <= degen_next;
        sel_ctl_reg   <= s_ctl;
        // Middle angle: asin for Tait-Bryan, acos for proper Euler.
        sel_y_reg[0]  <= s_ctl.proper ? root_s : mid_s;
        sel_x_reg[0]  <= s_ctl.proper ? mid_s : root_s;
        // First angle: locked formula under gimbal lock.
        sel_y_reg[1]  <= degen_next ? s_terms[rm2eu_pkg::SLOT_LY*EW +: EW]
                                    : s_terms[rm2eu_pkg::SLOT_FY*EW +: EW];
        sel_x_reg[1]  <= degen_next ? s_terms[rm2eu_pkg::SLOT_LX*EW +: EW]
                                    : s_terms[rm2eu_pkg::SLOT_FX*EW +: EW];
        sel_y_reg[2]  <= s_terms[rm2eu_pkg::SLOT_TY*EW +: EW];
        sel_x_reg[2]  <= s_terms[rm2eu_pkg::SLOT_TX*EW +: EW];
    end

    // Three arctangents in lockstep.
    logic             c_valid;
    logic [31:0]      c_z [3];
    logic [CTL_W:0]   c_side;
    rm2eu_pkg::ctl_t  c_ctl;
    logic             c_degen;

    rm2eu_cordic #(.EW(EW), .STEPS(CORDIC_STEPS), .SW(CTL_W+1), .LANES(3)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid_reg),
        .in_y      (sel_y_reg),
        .in_x      (sel_x_reg),
        .in_side   ({sel_degen_reg, sel_ctl_reg}),
        .out_valid (c_valid),
        .out_z     (c_z),
        .out_side  (c_side)
    );

    assign c_ctl   = c_side[CTL_W-1:0];
    assign c_degen = c_side[CTL_W];

    // ------------------------------------------------------------------
    // Output stage: rounding, sign handling and reserved-order zeroing.
    // ------------------------------------------------------------------
    logic          done_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] c_reg;
    logic          dg_reg;
    logic [AW-1:0] a_next;
    logic [AW-1:0] b_next;
    logic [AW-1:0] c_next;
    logic          dg_next;

    always_comb
    begin
        logic [31:0] zb;
        zb      = c_ctl.proper ? (32'd0 - c_z[0]) : c_z[0];
        a_next  = to_angle(c_z[1]);
        b_next  = to_angle(zb);
        c_next  = c_degen ? '0 : to_angle(c_z[2]);
        dg_next = c_degen;
        if (c_ctl.intrinsic)
        begin
            a_next = AW'(0) - a_next;
            b_next = AW'(0) - b_next;
            c_next = AW'(0) - c_next;
        end
        if (c_ctl.reserved)
        begin
            a_next  = '0;
            b_next  = '0;
            c_next  = '0;
            dg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        dg_reg <= dg_next;
    end

    assign done         = done_reg;
    assign first_angle  = a_reg;
    assign middle_angle = b_reg;
    assign third_angle  = c_reg;
    assign degenerate   = dg_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The back end drains a beat every cycle, so the queue never overflows.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && f_valid))
        else $error("queue written while full");

    // Under gimbal lock the third angle is forced to zero.
    a_degen_third_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (third_angle == '0))
        else $error("third angle not zero under gimbal lock");

    // A result beat follows every beat leaving the CORDIC pipeline.
    a_done_follows_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid |=> done)
        else $error("result beat lost after CORDIC");

endmodule
